>>> rtl/qslerp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared constants, types and the CORDIC arctangent table for the slerp block.
// ----------------------------------------------------------------------------
package qslerp_pkg;

  localparam int FRAC_BITS    = 14;
  localparam int CORDIC_STEPS = 16;
  localparam int IFB          = 30;
  localparam int ONE          = 1 << FRAC_BITS;

  localparam int CW    = 34;
  localparam int NW    = 2 * FRAC_BITS + 1;
  localparam int SQ_SH = 2 * (IFB - FRAC_BITS);
  localparam int SQ_N  = (NW + SQ_SH + 1) / 2;
  localparam int QB    = 34;
  localparam int DW    = 32;
  localparam int WW    = QB;

  localparam int LS    = SQ_N;
  localparam int LV    = CORDIC_STEPS;
  localparam int LR    = CORDIC_STEPS;
  localparam int LD    = QB + 2;
  localparam int K_ANG = LS + LV;
  localparam int K_ROT = K_ANG + 1;
  localparam int K_W   = K_ROT + LR + LD;

  typedef logic signed [CW-1:0] cval_t;

  typedef struct packed {
    logic [3:0][15:0]          p;
    logic [3:0][16:0]          q;
    logic [14:0]               w;
    logic [FRAC_BITS-1:0]      c;
    logic                      sph;
  } side_t;

  function automatic cval_t atan_val(input int i);
    cval_t v;
    case (i)
      0:  v = cval_t'(64'd843314857);
      1:  v = cval_t'(64'd497837829);
      2:  v = cval_t'(64'd263043837);
      3:  v = cval_t'(64'd133525159);
      4:  v = cval_t'(64'd67021687);
      5:  v = cval_t'(64'd33543516);
      6:  v = cval_t'(64'd16775851);
      7:  v = cval_t'(64'd8388437);
      8:  v = cval_t'(64'd4194283);
      9:  v = cval_t'(64'd2097149);
      10: v = cval_t'(64'd1048576);
      11: v = cval_t'(64'd524288);
      12: v = cval_t'(64'd262144);
      13: v = cval_t'(64'd131072);
      14: v = cval_t'(64'd65536);
      15: v = cval_t'(64'd32768);
      16: v = cval_t'(64'd16384);
      17: v = cval_t'(64'd8192);
      18: v = cval_t'(64'd4096);
      19: v = cval_t'(64'd2048);
      20: v = cval_t'(64'd1024);
      21: v = cval_t'(64'd512);
      22: v = cval_t'(64'd256);
      23: v = cval_t'(64'd128);
      24: v = cval_t'(64'd64);
      25: v = cval_t'(64'd32);
      26: v = cval_t'(64'd16);
      27: v = cval_t'(64'd8);
      28: v = cval_t'(64'd4);
      29: v = cval_t'(64'd2);
      30: v = cval_t'(64'd1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/quaternion_slerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_slerp
// Fixed-point Q1.14 quaternion slerp with linear fallback near alignment.
//
//   channel | dir | word
//   in_     | in  | start x,y,z,w, end x,y,z,w, blend_weight (144 bits)
//   out_    | out | blend x,y,z,w (64 bits)
//   cfg_    | in  | near_threshold (10 bits)
//
// One word per cycle sustained while the output queue is not full; the path
// runs through the 31-stage square root, two 16-stage CORDICs and 34-bit dividers.
// rst_n clears valid bits, output queue and near_threshold.
// A two-word output queue takes results while out_tready is low; the whole
// pipeline holds only when the queue is full.
// ----------------------------------------------------------------------------
module quaternion_slerp import qslerp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // start_x, start_y, start_z, start_w, end_x, end_y, end_z, end_w, blend_weight
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // blend_x, blend_y, blend_z, blend_w
  output logic [63:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [9:0]   cfg_data
);

  localparam int DOTW = 34;
  localparam int DCW  = DOTW - FRAC_BITS;
  localparam int PW   = CW + FRAC_BITS + 2;
  localparam int OPW  = WW + 17;
  localparam int SW   = OPW + 1;
  localparam logic signed [SW-1:0] RND = SW'(64'd1 << (IFB - 1));

  logic       en;
  logic [9:0] thr_r;

  // stage 1
  logic signed [15:0] in_p [4];
  logic signed [15:0] in_q [4];
  logic [14:0]        in_w;
  logic               vld1_r;
  logic signed [15:0] p1_r    [4];
  logic signed [15:0] q1_r    [4];
  logic signed [31:0] prod1_r [4];
  logic [14:0]        w1_r;

  // stage 2
  logic signed [DOTW-1:0] dot;
  logic [DOTW-1:0]        dmag;
  logic                   vld2_r;
  logic [3:0][15:0]       p2_r;
  logic [3:0][16:0]       q2_r;
  logic [14:0]            w2_r;
  logic [DCW-1:0]         c2_r;

  // stage 3
  logic signed [DCW:0]      diff;
  logic                     vld3_r;
  side_t                    side3_r;
  logic [2*FRAC_BITS-1:0]   csq3_r;

  // main pipe
  side_t          side_r [K_W+2];
  logic           vld_r  [K_W+3];
  logic [NW-1:0]  n_r;

  logic [SQ_N-1:0] root;
  cval_t           om;
  cval_t           om_r, ap_r, aq_r;
  cval_t           so, sp, sq;
  logic signed [WW-1:0] qp, qq;
  logic            dpos_p, dpos_q;
  logic [FRAC_BITS:0] wm_ang, wm_w;

  logic signed [WW-1:0]  wp_r, wq_r;
  logic signed [OPW-1:0] pp_r [4];
  logic signed [OPW-1:0] qq_r [4];

  // output queue
  logic [63:0] res;
  logic [63:0] mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push, pop;

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  // stage 1: unpack, clamp weight, multiply
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      in_p[i] = $signed(in_tdata[16*i +: 16]);
      in_q[i] = $signed(in_tdata[64 + 16*i +: 16]);
    end
    in_w = (in_tdata[128 +: 15] > 15'(ONE)) ? 15'(ONE) : in_tdata[128 +: 15];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1_r <= in_w;
      for (int i = 0; i < 4; i++) begin
        p1_r[i]    <= in_p[i];
        q1_r[i]    <= in_q[i];
        prod1_r[i] <= 32'(in_p[i]) * 32'(in_q[i]);
      end
    end
  end

  // stage 2: dot, sign fold
  assign dot  = DOTW'(prod1_r[0]) + DOTW'(prod1_r[1]) + DOTW'(prod1_r[2])
              + DOTW'(prod1_r[3]);
  assign dmag = dot[DOTW-1] ? DOTW'(-dot) : DOTW'(dot);

  always_ff @(posedge clk) begin
    if (en) begin
      w2_r <= w1_r;
      c2_r <= dmag[DOTW-1:FRAC_BITS];
      for (int i = 0; i < 4; i++) begin
        p2_r[i] <= p1_r[i];
        q2_r[i] <= dot[DOTW-1] ? -(17'(q1_r[i])) : 17'(q1_r[i]);
      end
    end
  end

  // stage 3: threshold, c squared
  assign diff = $signed((DCW+1)'(ONE)) - $signed({1'b0, c2_r});

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r.p   <= p2_r;
      side3_r.q   <= q2_r;
      side3_r.w   <= w2_r;
      side3_r.c   <= c2_r[FRAC_BITS-1:0];
      side3_r.sph <= diff > $signed((DCW+1)'(thr_r));
      csq3_r      <= (2*FRAC_BITS)'(c2_r[FRAC_BITS-1:0])
                   * (2*FRAC_BITS)'(c2_r[FRAC_BITS-1:0]);
    end
  end

  // stage 4 and sideband line
  always_ff @(posedge clk) begin
    if (en) begin
      n_r       <= (NW'(1) << (2*FRAC_BITS)) - NW'(csq3_r);
      side_r[0] <= side3_r;
      for (int i = 1; i < K_W + 2; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      for (int i = 0; i < K_W + 3; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld1_r   <= in_tvalid;
      vld2_r   <= vld1_r;
      vld3_r   <= vld2_r;
      vld_r[0] <= vld3_r;
      for (int i = 1; i < K_W + 3; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  qslerp_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .n_in (n_r),
    .root (root)
  );

  qslerp_cordic_vec u_vec (
    .clk   (clk),
    .en    (en),
    .x_in  (cval_t'({side_r[LS].c, {(IFB-FRAC_BITS){1'b0}}})),
    .y_in  (cval_t'(root)),
    .angle (om)
  );

  // angle split
  assign wm_ang = (FRAC_BITS+1)'(ONE) - side_r[K_ANG].w;

  always_ff @(posedge clk) begin
    if (en) begin
      om_r <= om;
      ap_r <= CW'((PW'($signed({1'b0, wm_ang})) * PW'(om)) >>> FRAC_BITS);
      aq_r <= CW'((PW'($signed({1'b0, side_r[K_ANG].w})) * PW'(om)) >>> FRAC_BITS);
    end
  end

  qslerp_cordic_rot u_rot_o (.clk(clk), .en(en), .z_in(om_r), .sine(so));
  qslerp_cordic_rot u_rot_p (.clk(clk), .en(en), .z_in(ap_r), .sine(sp));
  qslerp_cordic_rot u_rot_q (.clk(clk), .en(en), .z_in(aq_r), .sine(sq));

  qslerp_div u_div_p (
    .clk     (clk),
    .en      (en),
    .num     (sp),
    .den     (so),
    .quo     (qp),
    .den_pos (dpos_p)
  );

  qslerp_div u_div_q (
    .clk     (clk),
    .en      (en),
    .num     (sq),
    .den     (so),
    .quo     (qq),
    .den_pos (dpos_q)
  );

  // weight select
  assign wm_w = (FRAC_BITS+1)'(ONE) - side_r[K_W].w;

  always_ff @(posedge clk) begin
    if (en) begin
      if (side_r[K_W].sph && dpos_p && dpos_q) begin
        wp_r <= qp;
        wq_r <= qq;
      end else begin
        wp_r <= WW'({wm_w, {(IFB-FRAC_BITS){1'b0}}});
        wq_r <= WW'({side_r[K_W].w, {(IFB-FRAC_BITS){1'b0}}});
      end
    end
  end

  // weighted products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        pp_r[i] <= OPW'(wp_r) * OPW'($signed(side_r[K_W+1].p[i]));
        qq_r[i] <= OPW'(wq_r) * OPW'($signed(side_r[K_W+1].q[i]));
      end
    end
  end

  // round, shift, saturate
  always_comb begin
    logic signed [SW-1:0] sm;
    logic signed [SW-1:0] r;
    for (int i = 0; i < 4; i++) begin
      sm = SW'(pp_r[i]) + SW'(qq_r[i]) + RND;
      r  = sm >>> IFB;
      if (r > SW'(32767)) begin
        res[16*i +: 16] = 16'h7fff;
      end else if (r < -SW'(32768)) begin
        res[16*i +: 16] = 16'h8000;
      end else begin
        res[16*i +: 16] = r[15:0];
      end
    end
  end

  assign push = en && vld_r[K_W+2];
  assign pop  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = mem_r[rd_ptr_r];

endmodule

>>> rtl/qslerp_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_isqrt
// Pipelined integer square root of n * 2^SQ_SH, one root bit per stage.
// ----------------------------------------------------------------------------
module qslerp_isqrt import qslerp_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [NW-1:0]   n_in,
  output logic [SQ_N-1:0] root
);

  localparam int RW = SQ_N + 3;

  logic [RW-1:0]   rem_r    [SQ_N];
  logic [SQ_N-1:0] root_r   [SQ_N];
  logic [NW-1:0]   n_r      [SQ_N];
  logic [RW-1:0]   rem_nxt  [SQ_N];
  logic [SQ_N-1:0] root_nxt [SQ_N];
  logic [NW-1:0]   n_nxt    [SQ_N];

  always_comb begin
    logic [RW-1:0]     rem_i;
    logic [SQ_N-1:0]   root_i;
    logic [NW-1:0]     n_i;
    logic [2*SQ_N-1:0] v;
    logic [RW+1:0]     t;
    logic [RW+1:0]     trial;
    for (int j = 0; j < SQ_N; j++) begin
      if (j == 0) begin
        rem_i  = '0;
        root_i = '0;
        n_i    = n_in;
      end else begin
        rem_i  = rem_r[j-1];
        root_i = root_r[j-1];
        n_i    = n_r[j-1];
      end
      v     = (2*SQ_N)'({n_i, {SQ_SH{1'b0}}});
      t     = {rem_i, v[2*(SQ_N-1-j) +: 2]};
      trial = (RW+2)'({root_i, 2'b01});
      n_nxt[j] = n_i;
      if (t >= trial) begin
        rem_nxt[j]  = RW'(t - trial);
        root_nxt[j] = {root_i[SQ_N-2:0], 1'b1};
      end else begin
        rem_nxt[j]  = RW'(t);
        root_nxt[j] = {root_i[SQ_N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < SQ_N; j++) begin
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
        n_r[j]    <= n_nxt[j];
      end
    end
  end

  assign root = root_r[SQ_N-1];

endmodule

>>> rtl/qslerp_cordic_vec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_cordic_vec
// Pipelined vectoring CORDIC: angle of (x, y), one rotation per stage.
// ----------------------------------------------------------------------------
module qslerp_cordic_vec import qslerp_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  cval_t x_in,
  input  cval_t y_in,
  output cval_t angle
);

  cval_t x_r   [CORDIC_STEPS];
  cval_t y_r   [CORDIC_STEPS];
  cval_t z_r   [CORDIC_STEPS];
  cval_t x_nxt [CORDIC_STEPS];
  cval_t y_nxt [CORDIC_STEPS];
  cval_t z_nxt [CORDIC_STEPS];

  always_comb begin
    cval_t xi, yi, zi, dx, dy;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) begin
        xi = x_in;
        yi = y_in;
        zi = '0;
      end else begin
        xi = x_r[i-1];
        yi = y_r[i-1];
        zi = z_r[i-1];
      end
      dx = yi >>> i;
      dy = xi >>> i;
      if (!yi[CW-1]) begin
        x_nxt[i] = xi + dx;
        y_nxt[i] = yi - dy;
        z_nxt[i] = zi + atan_val(i);
      end else begin
        x_nxt[i] = xi - dx;
        y_nxt[i] = yi + dy;
        z_nxt[i] = zi - atan_val(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        x_r[i] <= x_nxt[i];
        y_r[i] <= y_nxt[i];
        z_r[i] <= z_nxt[i];
      end
    end
  end

  assign angle = z_r[CORDIC_STEPS-1];

endmodule

>>> rtl/qslerp_cordic_rot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_cordic_rot
// Pipelined rotation CORDIC from (2^30, 0): gain-scaled sine of an angle.
// ----------------------------------------------------------------------------
module qslerp_cordic_rot import qslerp_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  cval_t z_in,
  output cval_t sine
);

  localparam cval_t X0 = cval_t'(64'd1 << IFB);

  cval_t x_r   [CORDIC_STEPS];
  cval_t y_r   [CORDIC_STEPS];
  cval_t z_r   [CORDIC_STEPS];
  cval_t x_nxt [CORDIC_STEPS];
  cval_t y_nxt [CORDIC_STEPS];
  cval_t z_nxt [CORDIC_STEPS];

  always_comb begin
    cval_t xi, yi, zi, dx, dy;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) begin
        xi = X0;
        yi = '0;
        zi = z_in;
      end else begin
        xi = x_r[i-1];
        yi = y_r[i-1];
        zi = z_r[i-1];
      end
      dx = yi >>> i;
      dy = xi >>> i;
      if (!zi[CW-1]) begin
        x_nxt[i] = xi - dx;
        y_nxt[i] = yi + dy;
        z_nxt[i] = zi - atan_val(i);
      end else begin
        x_nxt[i] = xi + dx;
        y_nxt[i] = yi - dy;
        z_nxt[i] = zi + atan_val(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        x_r[i] <= x_nxt[i];
        y_r[i] <= y_nxt[i];
        z_r[i] <= z_nxt[i];
      end
    end
  end

  assign sine = y_r[CORDIC_STEPS-1];

endmodule

>>> rtl/qslerp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qslerp_div
// Pipelined restoring divider: num * 2^30 / den, truncated toward zero and
// clamped to +/-2^32, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qslerp_div import qslerp_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  cval_t                num,
  input  cval_t                den,
  output logic signed [WW-1:0] quo,
  output logic                 den_pos
);

  localparam int OS = QB - IFB;
  localparam int AW = CW + IFB;
  localparam logic [QB-1:0] LIM = QB'(64'd1 << (IFB + 2));

  // prep stage
  logic [CW-1:0] mag;
  logic [DW-1:0] rem0_r, d0_r;
  logic [AW-1:0] a0_r;
  logic          neg0_r, ov0_r, pos0_r;

  logic [DW-1:0] rem_r   [QB];
  logic [QB-1:0] q_r     [QB];
  logic [DW-1:0] d_r     [QB];
  logic [AW-1:0] a_r     [QB];
  logic          neg_r   [QB];
  logic          ov_r    [QB];
  logic          pos_r   [QB];
  logic [DW-1:0] rem_nxt [QB];
  logic [QB-1:0] q_nxt   [QB];

  logic [QB-1:0] mg;

  assign mag = num[CW-1] ? CW'(-num) : CW'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      neg0_r <= num[CW-1];
      pos0_r <= (den > cval_t'(0));
      d0_r   <= den[DW-1:0];
      a0_r   <= {mag, {IFB{1'b0}}};
      rem0_r <= DW'(mag >> OS);
      ov0_r  <= ({1'b0, mag} >= {den[DW-1:0], {OS{1'b0}}});
    end
  end

  always_comb begin
    logic [DW-1:0] rem_i, d_i;
    logic [QB-1:0] q_i;
    logic [AW-1:0] a_i;
    logic [DW:0]   t;
    for (int j = 0; j < QB; j++) begin
      if (j == 0) begin
        rem_i = rem0_r;
        q_i   = '0;
        d_i   = d0_r;
        a_i   = a0_r;
      end else begin
        rem_i = rem_r[j-1];
        q_i   = q_r[j-1];
        d_i   = d_r[j-1];
        a_i   = a_r[j-1];
      end
      t = {rem_i, a_i[QB-1-j]};
      if (t >= {1'b0, d_i}) begin
        rem_nxt[j] = DW'(t - {1'b0, d_i});
        q_nxt[j]   = {q_i[QB-2:0], 1'b1};
      end else begin
        rem_nxt[j] = DW'(t);
        q_nxt[j]   = {q_i[QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < QB; j++) begin
        rem_r[j] <= rem_nxt[j];
        q_r[j]   <= q_nxt[j];
        d_r[j]   <= (j == 0) ? d0_r   : d_r[j-1];
        a_r[j]   <= (j == 0) ? a0_r   : a_r[j-1];
        neg_r[j] <= (j == 0) ? neg0_r : neg_r[j-1];
        ov_r[j]  <= (j == 0) ? ov0_r  : ov_r[j-1];
        pos_r[j] <= (j == 0) ? pos0_r : pos_r[j-1];
      end
    end
  end

  assign mg = (ov_r[QB-1] || q_r[QB-1] > LIM) ? LIM : q_r[QB-1];

  always_ff @(posedge clk) begin
    if (en) begin
      quo     <= neg_r[QB-1] ? -$signed(mg) : $signed(mg);
      den_pos <= pos_r[QB-1];
    end
  end

endmodule
